>>> rtl/qrm_pkg.sv
// Shared widths and types for the quaternion to rotation matrix unit.
// No dependencies.
`default_nettype none
package qrm_pkg;
	localparam int CW = 16;         // component width, signed Q2.(CW-2)
	localparam int FB = CW - 2;     // fraction bits
	localparam int PW = 2 * CW;     // product width
	localparam int NW = PW + 1;     // squared norm width, unsigned
	localparam int SW = NW + 1;     // signed numerator width
	localparam int RW = NW + 1;     // partial remainder width
	localparam int QB = FB + 2;     // quotient bits before rounding
	localparam int NL = 9;          // matrix entries

	typedef logic signed [CW-1:0] comp_t;
	typedef logic signed [PW-1:0] prod_t;
	typedef logic signed [SW-1:0] num_t;
	typedef logic [NW-1:0]        norm_t;
	typedef logic [RW-1:0]        rem_t;
	typedef logic [QB-1:0]        quo_t;

	localparam comp_t UNIT = comp_t'(2 ** FB);

	typedef struct packed {
		logic  zero;
		norm_t n;
	} div_ctl_t;

	typedef struct packed {
		logic neg;
		rem_t rem;
		quo_t quo;
	} div_lane_t;
endpackage
`default_nettype wire

>>> rtl/qrm_quat_if.sv
// Request channel carrying one quaternion.
// Depends on qrm_pkg.
`default_nettype none
interface qrm_quat_if import qrm_pkg::*;;
	logic  valid;
	logic  ready;
	comp_t quat_x;
	comp_t quat_y;
	comp_t quat_z;
	comp_t quat_w;

	modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
	modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface
`default_nettype wire

>>> rtl/qrm_mat_if.sv
// Result channel carrying the nine rotation entries and the zero flag.
// Depends on qrm_pkg.
`default_nettype none
interface qrm_mat_if import qrm_pkg::*;;
	logic  valid;
	logic  ready;
	comp_t elem0;
	comp_t elem1;
	comp_t elem2;
	comp_t elem4;
	comp_t elem5;
	comp_t elem6;
	comp_t elem8;
	comp_t elem9;
	comp_t elem10;
	logic  zero_norm;

	modport source (output valid, elem0, elem1, elem2, elem4, elem5, elem6, elem8,
		elem9, elem10, zero_norm, input ready);
	modport sink (input valid, elem0, elem1, elem2, elem4, elem5, elem6, elem8,
		elem9, elem10, zero_norm, output ready);
endinterface
`default_nettype wire

>>> rtl/quaternion_to_rotation_matrix_unit.sv
// Quaternion to 3x3 rotation matrix: one quaternion request per cycle, Q2.14 in and out.
// Each entry is its numerator over x*x+y*y+z*z+w*w, rounded to nearest, ties away from
// zero, so unnormalised quaternions are fine. A zero quaternion gives zero entries and
// sets zero_norm. The stages in order: products, sums, magnitudes, one stage per quotient
// bit of the divider, then rounding into the output register. Throughput is one request
// per cycle; stalls hold every stage in place.
// Depends on qrm_pkg, qrm_quat_if, qrm_mat_if and qrm_divider.
`default_nettype none
module quaternion_to_rotation_matrix_unit import qrm_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	qrm_quat_if.sink quat,
	qrm_mat_if.source mat
);
	logic  v_s1, v_s2, v_s3, v_s4;
	logic  rdy1, rdy2, rdy3, rdy4;
	prod_t xx_s1, yy_s1, zz_s1, ww_s1, xy_s1, xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;
	norm_t n_s2;
	num_t  num_s2 [NL];
	div_ctl_t           ctl_s3;
	div_lane_t [NL-1:0] lane_s3;
	logic               dv_rdy, dv_vld;
	div_ctl_t           dv_ctl;
	div_lane_t [NL-1:0] dv_lane;
	comp_t              elem_s4 [NL];
	logic               zero_s4;

	assign rdy4 = ~v_s4 | mat.ready;
	assign rdy3 = ~v_s3 | dv_rdy;
	assign rdy2 = ~v_s2 | rdy3;
	assign rdy1 = ~v_s1 | rdy2;
	assign quat.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= quat.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= dv_vld;
		end
	end

	// products
	always_ff @(posedge clk) begin
		if (rdy1 && quat.valid) begin
			xx_s1 <= quat.quat_x * quat.quat_x;
			yy_s1 <= quat.quat_y * quat.quat_y;
			zz_s1 <= quat.quat_z * quat.quat_z;
			ww_s1 <= quat.quat_w * quat.quat_w;
			xy_s1 <= quat.quat_x * quat.quat_y;
			xz_s1 <= quat.quat_x * quat.quat_z;
			yz_s1 <= quat.quat_y * quat.quat_z;
			wx_s1 <= quat.quat_w * quat.quat_x;
			wy_s1 <= quat.quat_w * quat.quat_y;
			wz_s1 <= quat.quat_w * quat.quat_z;
		end
	end

	// numerators and norm
	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			n_s2 <= NW'($unsigned(xx_s1)) + NW'($unsigned(yy_s1))
				+ NW'($unsigned(zz_s1)) + NW'($unsigned(ww_s1));
			num_s2[0] <= SW'(ww_s1) + SW'(xx_s1) - SW'(yy_s1) - SW'(zz_s1);
			num_s2[1] <= (SW'(xy_s1) + SW'(wz_s1)) <<< 1;
			num_s2[2] <= (SW'(xz_s1) - SW'(wy_s1)) <<< 1;
			num_s2[3] <= (SW'(xy_s1) - SW'(wz_s1)) <<< 1;
			num_s2[4] <= SW'(ww_s1) + SW'(yy_s1) - SW'(xx_s1) - SW'(zz_s1);
			num_s2[5] <= (SW'(yz_s1) + SW'(wx_s1)) <<< 1;
			num_s2[6] <= (SW'(xz_s1) + SW'(wy_s1)) <<< 1;
			num_s2[7] <= (SW'(yz_s1) - SW'(wx_s1)) <<< 1;
			num_s2[8] <= SW'(ww_s1) + SW'(zz_s1) - SW'(xx_s1) - SW'(yy_s1);
		end
	end

	// sign and magnitude
	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			ctl_s3.zero <= (n_s2 == '0);
			ctl_s3.n    <= n_s2;
			for (int j = 0; j < NL; j++) begin
				lane_s3[j].neg <= num_s2[j][SW-1];
				lane_s3[j].rem <= num_s2[j][SW-1] ? RW'($unsigned(-num_s2[j]))
					: RW'($unsigned(num_s2[j]));
				lane_s3[j].quo <= '0;
			end
		end
	end

	qrm_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_ready  (dv_rdy),
		.in_ctl    (ctl_s3),
		.in_lane   (lane_s3),
		.out_valid (dv_vld),
		.out_ready (rdy4),
		.out_ctl   (dv_ctl),
		.out_lane  (dv_lane)
	);

	// round half away from zero, restore sign
	always_ff @(posedge clk) begin
		logic [QB:0]  rnd;
		logic [QB-1:0] mag;
		if (rdy4 && dv_vld) begin
			zero_s4 <= dv_ctl.zero;
			for (int j = 0; j < NL; j++) begin
				rnd = {1'b0, dv_lane[j].quo} + (QB+1)'(1);
				mag = rnd[QB:1];
				if (dv_ctl.zero)
					elem_s4[j] <= '0;
				else if (dv_lane[j].neg)
					elem_s4[j] <= CW'(-mag);
				else
					elem_s4[j] <= CW'(mag);
			end
		end
	end

	assign mat.valid     = v_s4;
	assign mat.zero_norm = zero_s4;
	assign mat.elem0     = elem_s4[0];
	assign mat.elem1     = elem_s4[1];
	assign mat.elem2     = elem_s4[2];
	assign mat.elem4     = elem_s4[3];
	assign mat.elem5     = elem_s4[4];
	assign mat.elem6     = elem_s4[5];
	assign mat.elem8     = elem_s4[6];
	assign mat.elem9     = elem_s4[7];
	assign mat.elem10    = elem_s4[8];

`ifndef SYNTHESIS
	a_zero_entries: assert property (@(posedge clk) disable iff (!arst_n)
		mat.valid && mat.zero_norm |-> mat.elem0 == '0 && mat.elem5 == '0
			&& mat.elem10 == '0 && mat.elem1 == '0 && mat.elem9 == '0)
		else $error("zero quaternion gave nonzero entries");
	a_diag_bound: assert property (@(posedge clk) disable iff (!arst_n)
		mat.valid |-> mat.elem0 <= UNIT && mat.elem0 >= -UNIT
			&& mat.elem5 <= UNIT && mat.elem5 >= -UNIT
			&& mat.elem10 <= UNIT && mat.elem10 >= -UNIT)
		else $error("diagonal entry beyond unity");
	a_offdiag_bound: assert property (@(posedge clk) disable iff (!arst_n)
		mat.valid |-> mat.elem1 <= UNIT && mat.elem1 >= -UNIT
			&& mat.elem2 <= UNIT && mat.elem2 >= -UNIT
			&& mat.elem4 <= UNIT && mat.elem4 >= -UNIT)
		else $error("off-diagonal entry beyond unity");
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !dv_rdy |=> v_s3 && $stable(ctl_s3))
		else $error("stage three request lost under stall");
`endif
endmodule
`default_nettype wire

>>> rtl/qrm_divider.sv
// Pipelined restoring divider, nine lanes sharing one divisor, one quotient bit per stage.
// Depends on qrm_pkg.
`default_nettype none
module qrm_divider import qrm_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire div_ctl_t             in_ctl,
	input  wire div_lane_t [NL-1:0]   in_lane,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output div_ctl_t                  out_ctl,
	output div_lane_t [NL-1:0]        out_lane
);
	logic [QB-1:0]       vld_s;
	logic [QB:0]         rdy;
	div_ctl_t            ctl_s  [QB];
	div_lane_t [NL-1:0]  lane_s [QB];

	assign rdy[QB]   = out_ready;
	assign in_ready  = rdy[0];
	assign out_valid = vld_s[QB-1];
	assign out_ctl   = ctl_s[QB-1];
	assign out_lane  = lane_s[QB-1];

	for (genvar k = 0; k < QB; k++) begin : g_stage
		logic               pv;
		div_ctl_t           pc;
		div_lane_t [NL-1:0] pl;
		div_lane_t [NL-1:0] nl;

		if (k == 0) begin : g_first
			assign pv = in_valid;
			assign pc = in_ctl;
			assign pl = in_lane;
		end else begin : g_next
			assign pv = vld_s[k-1];
			assign pc = ctl_s[k-1];
			assign pl = lane_s[k-1];
		end

		assign rdy[k] = ~vld_s[k] | rdy[k+1];

		always_comb begin
			rem_t trial;
			for (int j = 0; j < NL; j++) begin
				trial = (k == 0) ? pl[j].rem : {pl[j].rem[RW-2:0], 1'b0};
				nl[j].neg = pl[j].neg;
				if (trial >= RW'(pc.n)) begin
					nl[j].rem = trial - RW'(pc.n);
					nl[j].quo = {pl[j].quo[QB-2:0], 1'b1};
				end else begin
					nl[j].rem = trial;
					nl[j].quo = {pl[j].quo[QB-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && pv) begin
				ctl_s[k]  <= pc;
				lane_s[k] <= nl;
			end
		end
	end
endmodule
`default_nettype wire
